FILE: rtl/circle_pair_overlap_resolve_macros.svh
// assertion macros for the circle pair overlap block
`ifndef CIRCLE_PAIR_OVERLAP_RESOLVE_MACROS_SVH
`define CIRCLE_PAIR_OVERLAP_RESOLVE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPOR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CPOR_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define CPOR_ASSERT(lbl, prop, msg)
`define CPOR_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/cpor_pkg.sv
package cpor_pkg;

	// depth of the queue between the front and the back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic full;
		logic empty;
	} cpor_qstat_t;

endpackage

FILE: rtl/circle_pair_overlap_resolve.sv
// circle pair overlap resolver
// slave stream carries one circle pair per transfer: both centres (signed q16.16)
// and both radii (unsigned q15.16); master stream returns the two corrected
// centres, with the overlap flag in m_tuser
// when the centre distance floor(sqrt(dx^2+dy^2)) is below the radius sum and
// the centres differ, each centre moves by half the overlap along the centre
// line, rounded half up; outputs saturate to the coordinate range
// throughput: one pair per cycle while m_tready stays high
// the square root in the front and the dividers in the back work one bit per stage
// the front (difference, squares, square root, overlap test) feeds a four-entry
// queue; the back (products, dividers, saturation) drains it into the output register
// when m_tready is low the back holds, the queue fills, then s_tready drops
// reset clears all valid flags and empties the queue; no clearing pass is needed
`include "circle_pair_overlap_resolve_macros.svh"
module circle_pair_overlap_resolve #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// first_x, first_y, first_radius, second_x, second_y, second_radius, zero pad
	input  logic [((6*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// first_new_x, first_new_y, second_new_x, second_new_y, zero pad
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// overlapped
	output logic m_tuser
);

	import cpor_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int OW = ((4 * W + 7) / 8) * 8;
	localparam int QW = 8 * W + 5;

	// front to queue
	logic          f_valid;
	logic [QW-1:0] f_data;
	logic          q_push, q_pop;
	logic [QW-1:0] q_data;
	cpor_qstat_t   q_stat;

	// back results
	logic [W-1:0]  x1n, y1n, x2n, y2n;
	logic          hit;

	cpor_front #(.W(W)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.first_x       (s_tdata[W-1:0]),
		.first_y       (s_tdata[2*W-1:W]),
		.first_radius  (s_tdata[3*W-2:2*W]),
		.second_x      (s_tdata[4*W-2:3*W-1]),
		.second_y      (s_tdata[5*W-2:4*W-1]),
		.second_radius (s_tdata[6*W-3:5*W-1]),
		.out_valid     (f_valid),
		.out_full      (q_stat.full),
		.out_data      (f_data)
	);

	// the front only moves its last stage on when the queue has room
	assign q_push = f_valid && !q_stat.full;

	cpor_queue #(.DW(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (f_data),
		.pop    (q_pop),
		.dout   (q_data),
		.stat   (q_stat)
	);

	cpor_back #(.W(W)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_stat.empty),
		.pop          (q_pop),
		.in_data      (q_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.first_new_x  (x1n),
		.first_new_y  (y1n),
		.second_new_x (x2n),
		.second_new_y (y2n),
		.overlapped   (hit)
	);

	// pack result fields, lowest first
	assign m_tdata = OW'({y2n, x2n, y1n, x1n});
	assign m_tuser = hit;

	`CPOR_NEVER(a_q_overflow, q_push && q_stat.full, "queue written while full")
	`CPOR_NEVER(a_q_underflow, q_pop && q_stat.empty, "queue read while empty")
	`CPOR_ASSERT(a_stall_cause, !s_tready |-> q_stat.full, "input stalled with queue room")

endmodule

FILE: rtl/cpor_front.sv
module cpor_front #(
	parameter int W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [W-1:0]      first_x,
	input  logic [W-1:0]      first_y,
	input  logic [W-2:0]      first_radius,
	input  logic [W-1:0]      second_x,
	input  logic [W-1:0]      second_y,
	input  logic [W-2:0]      second_radius,
	output logic              out_valid,
	input  logic              out_full,
	output logic [8*W+4:0]    out_data
);

	localparam int AW = W + 1;
	localparam int SW = 2 * W + 2;
	localparam int RW = W + 1;
	localparam int PW = 7 * W + 5;

	logic          en;
	logic [W:0]    dx, dy;
	logic [AW-1:0] adx, ady;
	logic [W-1:0]  m;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PW-1:0] pl_s1, pl_s2, pl_s3;
	logic [SW-1:0] sqx_s2, sqy_s2, s_s3;
	logic [8*W+4:0] dat_s4;

	logic          rt_vld_s  [1:RW];
	logic [SW-1:0] rt_rem_s  [1:RW];
	logic [RW-1:0] rt_root_s [1:RW];
	logic [PW-1:0] rt_pl_s   [1:RW];

	logic [RW-1:0] d;
	logic [W-1:0]  mq;
	logic          hit;

	assign en       = !vld_s4 || !out_full;
	assign in_ready = en;

	assign dx  = {first_x[W-1], first_x} - {second_x[W-1], second_x};
	assign dy  = {first_y[W-1], first_y} - {second_y[W-1], second_y};
	assign adx = dx[W] ? AW'(~dx + 1'b1) : dx;
	assign ady = dy[W] ? AW'(~dy + 1'b1) : dy;
	assign m   = {1'b0, first_radius} + {1'b0, second_radius};

	// difference, square, sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= {((dx != '0) || (dy != '0)), dy[W], ady, dx[W], adx, m,
				second_y, second_x, first_y, first_x};
			sqx_s2 <= SW'(pl_s1[6*W:5*W]) * SW'(pl_s1[6*W:5*W]);
			sqy_s2 <= SW'(pl_s1[7*W+2:6*W+2]) * SW'(pl_s1[7*W+2:6*W+2]);
			pl_s2  <= pl_s1;
			s_s3   <= sqx_s2 + sqy_s2;
			pl_s3  <= pl_s2;
		end
	end

	// square root, one result bit per stage, remainder kept as s - root^2
	for (genvar k = 0; k < RW; k++) begin : g_rt
		localparam int I = RW - 1 - k;
		logic          vin;
		logic [SW-1:0] rin, trial;
		logic [RW-1:0] oin;
		logic [PW-1:0] pin;
		logic          take;
		if (k == 0) begin : g_first
			assign vin = vld_s3;
			assign rin = s_s3;
			assign oin = '0;
			assign pin = pl_s3;
		end else begin : g_next
			assign vin = rt_vld_s[k];
			assign rin = rt_rem_s[k];
			assign oin = rt_root_s[k];
			assign pin = rt_pl_s[k];
		end
		assign trial = (SW'(oin) << (I + 1)) | (SW'(1) << (2 * I));
		assign take  = rin >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k+1]  <= take ? rin - trial : rin;
				rt_root_s[k+1] <= take ? (oin | (RW'(1) << I)) : oin;
				rt_pl_s[k+1]   <= pin;
			end
		end
	end

	// classify: overlap when centres differ and distance below radius sum
	assign d   = rt_root_s[RW];
	assign mq  = rt_pl_s[RW][5*W-1:4*W];
	assign hit = rt_pl_s[RW][7*W+4] && (RW'(mq) > d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= rt_vld_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s4 <= {hit, mq - d[W-1:0], d[W-1:0], rt_pl_s[RW][7*W+3:5*W],
				rt_pl_s[RW][4*W-1:0]};
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = dat_s4;

endmodule

FILE: rtl/cpor_queue.sv
module cpor_queue #(
	parameter int DW = 261
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DW-1:0]       din,
	input  logic                pop,
	output logic [DW-1:0]       dout,
	output cpor_pkg::cpor_qstat_t stat
);

	import cpor_pkg::*;

	logic [DW-1:0]  mem_q [0:QDEPTH-1];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	assign dout       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == QCW'(QDEPTH);
	assign stat.empty = cnt_q == '0;

endmodule

FILE: rtl/cpor_div.sv
module cpor_div #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W:0]   num,
	input  logic [W:0]     den,
	output logic [W-1:0]   quo
);

	// restoring division, one quotient bit per stage
	logic [W:0]   rem_s [1:W];
	logic [W-1:0] nm_s  [1:W];
	logic [W:0]   dn_s  [1:W];
	logic [W-1:0] qt_s  [1:W];

	for (genvar k = 0; k < W; k++) begin : g_dv
		localparam int I = W - 1 - k;
		logic [W:0]   rin, din;
		logic [W-1:0] nin, qin;
		logic [W+1:0] rem2, diff;
		logic         take;
		if (k == 0) begin : g_first
			assign rin = num[2*W:W];
			assign nin = num[W-1:0];
			assign din = den;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k];
			assign nin = nm_s[k];
			assign din = dn_s[k];
			assign qin = qt_s[k];
		end
		assign rem2 = {rin, nin[I]};
		assign diff = rem2 - {1'b0, din};
		assign take = rem2 >= {1'b0, din};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[W:0] : rem2[W:0];
				nm_s[k+1]  <= nin;
				dn_s[k+1]  <= din;
				qt_s[k+1]  <= take ? (qin | (W'(1) << I)) : qin;
			end
		end
	end

	assign quo = qt_s[W];

endmodule

FILE: rtl/cpor_back.sv
module cpor_back #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           pop,
	input  logic [8*W+4:0] in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [W-1:0]   first_new_x,
	output logic [W-1:0]   first_new_y,
	output logic [W-1:0]   second_new_x,
	output logic [W-1:0]   second_new_y,
	output logic           overlapped
);

	localparam int NW = 2 * W + 1;
	localparam int BW = 5 * W + 3;

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] c, input logic [W-1:0] q,
		input logic neg);
		logic [W+1:0] cx, qx, sum;
		cx  = {{2{c[W-1]}}, c};
		qx  = {2'b00, q};
		sum = neg ? cx - qx : cx + qx;
		if (sum[W+1:W-1] == 3'b000 || sum[W+1:W-1] == 3'b111) begin
			return sum[W-1:0];
		end else if (sum[W+1]) begin
			return {1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	logic          en;
	logic          vld_s1, vld_s2, vld_o_q;
	logic [NW-1:0] prx_s1, pry_s1, numx_s2, numy_s2;
	logic [W:0]    den_s2;
	logic [BW-1:0] pl_s1, pl_s2;
	logic          dv_vld_s [1:W];
	logic [BW-1:0] dv_pl_s  [1:W];
	logic [W-1:0]  qx, qy, qxm, qym;
	logic [BW-1:0] pe;
	logic [W-1:0]  x1n_q, y1n_q, x2n_q, y2n_q;
	logic          hit_q;

	assign en  = !vld_o_q || out_ready;
	assign pop = en && in_valid;

	// payload: x1 y1 x2 y2, signs, distance, hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s1  <= NW'(in_data[8*W+3:7*W+4]) * NW'(in_data[5*W:4*W]);
			pry_s1  <= NW'(in_data[8*W+3:7*W+4]) * NW'(in_data[6*W+2:5*W+2]);
			pl_s1   <= {in_data[8*W+4], in_data[7*W+3:6*W+4], in_data[6*W+3],
				in_data[5*W+1], in_data[4*W-1:0]};
			numx_s2 <= prx_s1 + NW'(pl_s1[5*W+1:4*W+2]);
			numy_s2 <= pry_s1 + NW'(pl_s1[5*W+1:4*W+2]);
			den_s2  <= {pl_s1[5*W+1:4*W+2], 1'b0};
			pl_s2   <= pl_s1;
		end
	end

	cpor_div #(.W(W)) u_divx (
		.clk (clk),
		.en  (en),
		.num (numx_s2),
		.den (den_s2),
		.quo (qx)
	);

	cpor_div #(.W(W)) u_divy (
		.clk (clk),
		.en  (en),
		.num (numy_s2),
		.den (den_s2),
		.quo (qy)
	);

	for (genvar k = 0; k < W; k++) begin : g_al
		logic          vin;
		logic [BW-1:0] pin;
		if (k == 0) begin : g_first
			assign vin = vld_s2;
			assign pin = pl_s2;
		end else begin : g_next
			assign vin = dv_vld_s[k];
			assign pin = dv_pl_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_pl_s[k+1] <= pin;
			end
		end
	end

	assign pe  = dv_pl_s[W];
	assign qxm = pe[5*W+2] ? qx : '0;
	assign qym = pe[5*W+2] ? qy : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_q <= 1'b0;
		end else if (en) begin
			vld_o_q <= dv_vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1n_q <= sat_add(pe[W-1:0], qxm, pe[4*W]);
			y1n_q <= sat_add(pe[2*W-1:W], qym, pe[4*W+1]);
			x2n_q <= sat_add(pe[3*W-1:2*W], qxm, !pe[4*W]);
			y2n_q <= sat_add(pe[4*W-1:3*W], qym, !pe[4*W+1]);
			hit_q <= pe[5*W+2];
		end
	end

	assign out_valid    = vld_o_q;
	assign first_new_x  = x1n_q;
	assign first_new_y  = y1n_q;
	assign second_new_x = x2n_q;
	assign second_new_y = y2n_q;
	assign overlapped   = hit_q;

endmodule
